// File: src/three_class_priority_shaper_unit_assert.svh
// Assertion macros for the three-class priority shaper.
// Each macro relies on clk and rst_n in the module that uses it.
`ifndef THREE_CLASS_PRIORITY_SHAPER_UNIT_ASSERT_SVH
`define THREE_CLASS_PRIORITY_SHAPER_UNIT_ASSERT_SVH

// same-cycle implication
`define TCPS_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define TCPS_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: src/tcps_pkg.sv
// Shared types, codes and helpers for the three-class priority shaper.
// No dependencies.
`timescale 1ns / 1ps
package tcps_pkg;

  localparam int unsigned DescSlotsDef = 16384;
  localparam int unsigned NumClasses   = 3;
  localparam int unsigned LimitReset   = 10240;
  localparam int unsigned NspbReset    = 800;
  localparam int unsigned MaxDrops     = 63;

  localparam logic [7:0] TosHighBit = 8'h10;
  localparam logic [7:0] TosLowBit  = 8'h08;

  typedef enum logic [1:0] {
    ACT_ENQ  = 2'd0,
    ACT_DEQ  = 2'd1,
    ACT_PEEK = 2'd2,
    ACT_HO   = 2'd3
  } action_t;

  typedef enum logic [2:0] {
    EV_WAIT    = 3'd0,
    EV_EMPTY   = 3'd1,
    EV_SENT    = 3'd2,
    EV_PEEKED  = 3'd3,
    EV_DROPPED = 3'd4,
    EV_ACC     = 3'd5,
    EV_ACC_CNG = 3'd6,
    EV_HO_DONE = 3'd7
  } event_t;

  localparam logic REG_LIMIT = 1'b0;
  localparam logic REG_NSPB  = 1'b1;

  typedef struct packed {
    event_t       ev;
    logic [13:0]  handle;
    logic [15:0]  len;
    logic [1:0]   cls;
    logic [63:0]  wake;
    logic [14:0]  count;
    logic         last;
  } result_t;

  function automatic logic [7:0] derive_tos(input logic [15:0] et, input logic complete,
                                            input logic [7:0] tos);
    logic [7:0] r;
    r = 8'h00;
    case (et)
      16'h0800, 16'h86DD: r = complete ? tos : 8'h00;
      16'h0806, 16'h8035, 16'h8863: r = TosHighBit;
      16'h0060, 16'h9000: r = TosLowBit;
      default: r = 8'h00;
    endcase
    return r;
  endfunction

  function automatic logic [63:0] sat_add(input logic [63:0] a, input logic [63:0] b);
    logic [64:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[64] ? {64{1'b1}} : s[63:0];
  endfunction

endpackage

// File: src/tcps_ram.sv
// Generic single-write, single-read synchronous RAM with registered read.
// No dependencies.
`timescale 1ns / 1ps
module tcps_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 16384
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: src/tcps_classify.sv
// Classifier: derives the TOS byte, the traffic class and the slot index of an
// enqueued packet. Depends on tcps_pkg.
`timescale 1ns / 1ps
module tcps_classify import tcps_pkg::*; #(
  parameter int unsigned DESC_SLOTS = DescSlotsDef
) (
  input  logic [15:0]                   ethertype,
  input  logic                          header_complete,
  input  logic [7:0]                    tos_field,
  input  logic [13:0]                   packet_handle,
  output logic [1:0]                    cls,
  output logic [$clog2(DESC_SLOTS)-1:0] slot
);

  localparam int unsigned IW = $clog2(DESC_SLOTS);

  logic [7:0] tos;

  assign tos = derive_tos(ethertype, header_complete, tos_field);

  always_comb begin
    cls = 2'd1;
    if ((tos & TosHighBit) != 8'h00 && (tos & TosLowBit) == 8'h00) begin
      cls = 2'd0;
    end else if ((tos & TosHighBit) == 8'h00 && (tos & TosLowBit) != 8'h00) begin
      cls = 2'd2;
    end
  end

  // slot count is a power of two: keep the low bits
  assign slot = IW'(packet_handle);

endmodule

// File: src/three_class_priority_shaper_unit.sv
// Three-class strict priority queue with a byte-rate shaper.
// Enqueue passes drop check and drop writeback once per head dropped, then append;
// dequeue passes check, link/length memory read and the shaping multiply, then add;
// peek passes check and read; handover passes multiply and add; wait or empty ends at
// check. A new item is taken only in idle, once the last result is registered. Reset clears class
// flags, count, time and credit at once; link and length memories need no clearing pass.
`timescale 1ns / 1ps
module three_class_priority_shaper_unit import tcps_pkg::*; #(
  parameter int unsigned DESC_SLOTS = DescSlotsDef
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_action,
  input  logic [15:0] in_ethertype,
  input  logic        in_header_complete,
  input  logic [7:0]  in_tos_field,
  input  logic [13:0] in_packet_handle,
  input  logic [15:0] in_packet_len,
  input  logic [63:0] in_now_ns,
  input  logic [31:0] in_delay_us,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  out_event_res,
  output logic [13:0] out_handle,
  output logic [15:0] out_len,
  output logic [1:0]  out_traffic_class,
  output logic [63:0] out_wake_time,
  output logic [14:0] out_queue_count,
  output logic        out_last,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [29:0] cfg_data
);

  localparam int unsigned IW = $clog2(DESC_SLOTS);

  typedef enum logic [8:0] {
    S_IDLE     = 9'b000000001,
    S_DROP_CHK = 9'b000000010,
    S_DROP_WB  = 9'b000000100,
    S_APPEND   = 9'b000001000,
    S_DQ_CHK   = 9'b000010000,
    S_DQ_RD    = 9'b000100000,
    S_DQ_ADD   = 9'b001000000,
    S_HO_MUL   = 9'b010000000,
    S_HO_ADD   = 9'b100000000
  } state_t;

  state_t         st_r, st_nxt;
  logic [IW-1:0]  head_r [NumClasses];
  logic [IW-1:0]  head_nxt [NumClasses];
  logic [IW-1:0]  tail_r [NumClasses];
  logic [IW-1:0]  tail_nxt [NumClasses];
  logic [2:0]     ne_r, ne_nxt;
  logic [14:0]    count_r, count_nxt;
  logic [63:0]    nst_r, nst_nxt;
  logic           credit_r, credit_nxt;
  logic [14:0]    limit_r, limit_nxt;
  logic [29:0]    nspb_r, nspb_nxt;

  action_t        act_r, act_nxt;
  logic [IW-1:0]  slot_r, slot_nxt;
  logic [1:0]     cls_r, cls_nxt;
  logic [15:0]    plen_r, plen_nxt;
  logic [63:0]    now_r, now_nxt;
  logic [31:0]    delay_r, delay_nxt;
  logic [IW-1:0]  h_r, h_nxt;
  logic [1:0]     c_r, c_nxt;
  logic [15:0]    hlen_r, hlen_nxt;
  logic [45:0]    prod_r, prod_nxt;
  logic [41:0]    hprod_r, hprod_nxt;
  logic           over_r, over_nxt;
  logic           silent_r, silent_nxt;
  logic [5:0]     drop_n_r, drop_n_nxt;

  logic           out_valid_r, out_valid_nxt;
  result_t        out_r, out_nxt;

  logic [1:0]     cls_in;
  logic [IW-1:0]  slot_in;
  logic           out_free;
  logic [1:0]     low_c, high_c;
  logic           any_ne;
  logic           rd_en;
  logic [IW-1:0]  rd_addr;
  logic           len_we, link_we;
  logic [IW-1:0]  link_waddr;
  logic [IW-1:0]  link_q;
  logic [15:0]    len_q;
  logic [63:0]    base_t, sent_t, until_t;
  logic [14:0]    count_dec;

  tcps_classify #(.DESC_SLOTS(DESC_SLOTS)) u_classify (
    .ethertype       (in_ethertype),
    .header_complete (in_header_complete),
    .tos_field       (in_tos_field),
    .packet_handle   (in_packet_handle),
    .cls             (cls_in),
    .slot            (slot_in)
  );

  tcps_ram #(.WIDTH(IW), .DEPTH(DESC_SLOTS)) u_link_ram (
    .clk   (clk),
    .we    (link_we),
    .waddr (link_waddr),
    .wdata (slot_r),
    .re    (rd_en),
    .raddr (rd_addr),
    .rdata (link_q)
  );

  tcps_ram #(.WIDTH(16), .DEPTH(DESC_SLOTS)) u_len_ram (
    .clk   (clk),
    .we    (len_we),
    .waddr (slot_r),
    .wdata (plen_r),
    .re    (rd_en),
    .raddr (rd_addr),
    .rdata (len_q)
  );

  assign out_free  = !out_valid_r || !out_stall;
  assign any_ne    = |ne_r;
  assign low_c     = ne_r[2] ? 2'd2 : (ne_r[1] ? 2'd1 : 2'd0);
  assign high_c    = ne_r[0] ? 2'd0 : (ne_r[1] ? 2'd1 : 2'd2);
  assign count_dec = count_r - 15'd1;
  assign base_t    = credit_r ? nst_r : now_r;
  assign sent_t    = sat_add(base_t, {18'd0, prod_r});
  assign until_t   = sat_add(now_r, {22'd0, hprod_r});

  assign in_stall  = (st_r != S_IDLE) || cfg_valid;
  assign cfg_ready = (st_r == S_IDLE);

  always_comb begin
    st_nxt        = st_r;
    head_nxt      = head_r;
    tail_nxt      = tail_r;
    ne_nxt        = ne_r;
    count_nxt     = count_r;
    nst_nxt       = nst_r;
    credit_nxt    = credit_r;
    limit_nxt     = limit_r;
    nspb_nxt      = nspb_r;
    act_nxt       = act_r;
    slot_nxt      = slot_r;
    cls_nxt       = cls_r;
    plen_nxt      = plen_r;
    now_nxt       = now_r;
    delay_nxt     = delay_r;
    h_nxt         = h_r;
    c_nxt         = c_r;
    hlen_nxt      = hlen_r;
    prod_nxt      = prod_r;
    hprod_nxt     = hprod_r;
    over_nxt      = over_r;
    silent_nxt    = silent_r;
    drop_n_nxt    = drop_n_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_nxt       = out_r;
    rd_en         = 1'b0;
    rd_addr       = head_r[low_c];
    len_we        = 1'b0;
    link_we       = 1'b0;
    link_waddr    = tail_r[cls_r];

    case (st_r)
      S_IDLE: begin
        if (cfg_valid) begin
          if (cfg_index == REG_LIMIT) begin
            limit_nxt = (cfg_data[14:0] == 15'd0) ? 15'd1 : cfg_data[14:0];
            if (count_r > limit_nxt) begin
              silent_nxt = 1'b1;
              st_nxt     = S_DROP_CHK;
            end
          end else begin
            nspb_nxt = (cfg_data == 30'd0) ? 30'd1 : cfg_data;
          end
        end else if (in_valid) begin
          act_nxt    = action_t'(in_action);
          slot_nxt   = slot_in;
          cls_nxt    = cls_in;
          plen_nxt   = in_packet_len;
          now_nxt    = in_now_ns;
          delay_nxt  = in_delay_us;
          silent_nxt = 1'b0;
          drop_n_nxt = 6'd0;
          case (action_t'(in_action))
            ACT_ENQ: begin
              count_nxt = count_r + 15'd1;
              over_nxt  = (count_r + 15'd1) >= limit_r;
              st_nxt    = ((count_r + 15'd1) >= limit_r) ? S_DROP_CHK : S_APPEND;
            end
            ACT_HO:  st_nxt = S_HO_MUL;
            default: st_nxt = S_DQ_CHK;
          endcase
        end
      end

      S_DROP_CHK: begin
        if (!any_ne || (!silent_r && drop_n_r == 6'(MaxDrops))) begin
          st_nxt = silent_r ? S_IDLE : S_APPEND;
        end else begin
          rd_en   = 1'b1;
          rd_addr = head_r[low_c];
          h_nxt   = head_r[low_c];
          c_nxt   = low_c;
          st_nxt  = S_DROP_WB;
        end
      end

      S_DROP_WB: begin
        if (silent_r || out_free) begin
          if (h_r == tail_r[c_r]) begin
            ne_nxt[c_r] = 1'b0;
          end else begin
            head_nxt[c_r] = link_q;
          end
          count_nxt  = count_dec;
          drop_n_nxt = drop_n_r + 6'd1;
          if (count_dec >= limit_r) begin
            st_nxt = S_DROP_CHK;
          end else begin
            st_nxt = silent_r ? S_IDLE : S_APPEND;
          end
          if (!silent_r) begin
            out_valid_nxt = 1'b1;
            out_nxt = '{ev: EV_DROPPED, handle: 14'(h_r), len: len_q, cls: c_r,
                        wake: nst_r, count: count_dec, last: 1'b0};
          end
        end
      end

      S_APPEND: begin
        if (out_free) begin
          len_we = 1'b1;
          if (ne_r[cls_r]) begin
            link_we = 1'b1;
          end else begin
            head_nxt[cls_r] = slot_r;
            ne_nxt[cls_r]   = 1'b1;
          end
          tail_nxt[cls_r] = slot_r;
          out_valid_nxt   = 1'b1;
          out_nxt = '{ev: over_r ? EV_ACC_CNG : EV_ACC, handle: 14'(slot_r), len: plen_r,
                      cls: cls_r, wake: nst_r, count: count_r, last: 1'b1};
          st_nxt = S_IDLE;
        end
      end

      S_DQ_CHK: begin
        if (now_r < nst_r) begin
          if (out_free) begin
            out_valid_nxt = 1'b1;
            out_nxt = '{ev: EV_WAIT, handle: 14'd0, len: 16'd0, cls: 2'd0,
                        wake: nst_r, count: count_r, last: 1'b1};
            st_nxt = S_IDLE;
          end
        end else if (count_r == 15'd0 || !any_ne) begin
          if (out_free) begin
            credit_nxt    = 1'b0;
            out_valid_nxt = 1'b1;
            out_nxt = '{ev: EV_EMPTY, handle: 14'd0, len: 16'd0, cls: 2'd0,
                        wake: nst_r, count: count_r, last: 1'b1};
            st_nxt = S_IDLE;
          end
        end else begin
          rd_en   = 1'b1;
          rd_addr = head_r[high_c];
          h_nxt   = head_r[high_c];
          c_nxt   = high_c;
          st_nxt  = S_DQ_RD;
        end
      end

      S_DQ_RD: begin
        if (act_r == ACT_PEEK) begin
          if (out_free) begin
            out_valid_nxt = 1'b1;
            out_nxt = '{ev: EV_PEEKED, handle: 14'(h_r), len: len_q, cls: c_r,
                        wake: nst_r, count: count_r, last: 1'b1};
            st_nxt = S_IDLE;
          end
        end else begin
          // pop now, advance the send time once the product is registered
          if (h_r == tail_r[c_r]) begin
            ne_nxt[c_r] = 1'b0;
          end else begin
            head_nxt[c_r] = link_q;
          end
          count_nxt = count_dec;
          hlen_nxt  = len_q;
          prod_nxt  = 46'(nspb_r) * 46'(len_q);
          st_nxt    = S_DQ_ADD;
        end
      end

      S_DQ_ADD: begin
        if (out_free) begin
          nst_nxt       = sent_t;
          credit_nxt    = 1'b1;
          out_valid_nxt = 1'b1;
          out_nxt = '{ev: EV_SENT, handle: 14'(h_r), len: hlen_r, cls: c_r,
                      wake: sent_t, count: count_r, last: 1'b1};
          st_nxt = S_IDLE;
        end
      end

      S_HO_MUL: begin
        hprod_nxt = 42'(delay_r) * 42'd1000;
        st_nxt    = S_HO_ADD;
      end

      S_HO_ADD: begin
        if (out_free) begin
          nst_nxt       = (until_t > nst_r) ? until_t : nst_r;
          credit_nxt    = 1'b0;
          out_valid_nxt = 1'b1;
          out_nxt = '{ev: EV_HO_DONE, handle: 14'd0, len: 16'd0, cls: 2'd0,
                      wake: (until_t > nst_r) ? until_t : nst_r, count: count_r,
                      last: 1'b1};
          st_nxt = S_IDLE;
        end
      end

      default: st_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= S_IDLE;
      ne_r        <= 3'b000;
      count_r     <= 15'd0;
      nst_r       <= 64'd0;
      credit_r    <= 1'b0;
      limit_r     <= 15'(LimitReset);
      nspb_r      <= 30'(NspbReset);
      out_valid_r <= 1'b0;
      silent_r    <= 1'b0;
      drop_n_r    <= 6'd0;
    end else begin
      st_r        <= st_nxt;
      ne_r        <= ne_nxt;
      count_r     <= count_nxt;
      nst_r       <= nst_nxt;
      credit_r    <= credit_nxt;
      limit_r     <= limit_nxt;
      nspb_r      <= nspb_nxt;
      out_valid_r <= out_valid_nxt;
      silent_r    <= silent_nxt;
      drop_n_r    <= drop_n_nxt;
    end
  end

  always_ff @(posedge clk) begin
    head_r  <= head_nxt;
    tail_r  <= tail_nxt;
    act_r   <= act_nxt;
    slot_r  <= slot_nxt;
    cls_r   <= cls_nxt;
    plen_r  <= plen_nxt;
    now_r   <= now_nxt;
    delay_r <= delay_nxt;
    h_r     <= h_nxt;
    c_r     <= c_nxt;
    hlen_r  <= hlen_nxt;
    prod_r  <= prod_nxt;
    hprod_r <= hprod_nxt;
    over_r  <= over_nxt;
    out_r   <= out_nxt;
  end

  assign out_valid         = out_valid_r;
  assign out_event_res     = out_r.ev;
  assign out_handle        = out_r.handle;
  assign out_len           = out_r.len;
  assign out_traffic_class = out_r.cls;
  assign out_wake_time     = out_r.wake;
  assign out_queue_count   = out_r.count;
  assign out_last          = out_r.last;

`include "three_class_priority_shaper_unit_assert.svh"

  `TCPS_ASSERT_NXT(a_credit_after_send, (st_r == S_DQ_ADD) && out_free, credit_r, "credit not set after send")
  `TCPS_ASSERT_IMP(a_drop_bound, (st_r == S_DROP_WB) && !silent_r, drop_n_r < 6'(MaxDrops), "too many drops in one enqueue")
  `TCPS_ASSERT_IMP(a_last_on_final, out_valid_r && (out_r.ev != EV_DROPPED), out_r.last, "final result without last")
  `TCPS_ASSERT_IMP(a_drop_not_last, out_valid_r && (out_r.ev == EV_DROPPED), !out_r.last, "drop beat marked last")

endmodule

// File: sim/testbench.sv
// Self-checking testbench for three_class_priority_shaper_unit.
// Depends on tcps_pkg; predicts every result beat and checks it in order.
`timescale 1ns / 1ps
module testbench;
  import tcps_pkg::*;

  localparam int Slots = 16384;
  localparam longint CycleLimit = 2000000;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [1:0]  in_action = '0;
  logic [15:0] in_ethertype = '0;
  logic        in_header_complete = 1'b0;
  logic [7:0]  in_tos_field = '0;
  logic [13:0] in_packet_handle = '0;
  logic [15:0] in_packet_len = '0;
  logic [63:0] in_now_ns = '0;
  logic [31:0] in_delay_us = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [2:0]  out_event_res;
  logic [13:0] out_handle;
  logic [15:0] out_len;
  logic [1:0]  out_traffic_class;
  logic [63:0] out_wake_time;
  logic [14:0] out_queue_count;
  logic        out_last;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic        cfg_index = 1'b0;
  logic [29:0] cfg_data = '0;

  three_class_priority_shaper_unit dut (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // shadow of the block's state
  logic [13:0] m_head [3];
  logic [13:0] m_tail [3];
  logic        m_busy [3];
  logic [13:0] m_link [Slots];
  logic [15:0] m_len [Slots];
  logic        m_used [Slots];
  int unsigned m_count;
  logic [63:0] m_next;
  logic        m_credit;
  int unsigned m_limit;
  logic [29:0] m_nspb;

  result_t expected_beats [$];
  int errors = 0;
  longint cycles = 0;
  int idle_pct = 37;
  bit hold_out = 1'b0;
  logic [63:0] clock_ns = 64'd0;

  function automatic logic [63:0] sadd(logic [63:0] a, logic [63:0] b);
    logic [64:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[64] ? '1 : s[63:0];
  endfunction

  function automatic void push_beat(event_t ev, logic [13:0] h, logic [15:0] l,
                                    logic [1:0] c, logic last);
    result_t r;
    r.ev = ev; r.handle = h; r.len = l; r.cls = c;
    r.wake = m_next; r.count = m_count[14:0]; r.last = last;
    expected_beats.push_back(r);
  endfunction

  function automatic logic [13:0] pop_class(int c);
    logic [13:0] h;
    h = m_head[c];
    if (h == m_tail[c]) m_busy[c] = 1'b0;
    else m_head[c] = m_link[h];
    return h;
  endfunction

  function automatic int drop_one(output int c, output logic [13:0] h);
    for (int k = 2; k >= 0; k--) begin
      if (m_busy[k]) begin
        c = k; h = pop_class(k); m_count--;
        return 1;
      end
    end
    return 0;
  endfunction

  function automatic int top_class();
    for (int k = 0; k < 3; k++) if (m_busy[k]) return k;
    return -1;
  endfunction

  function automatic logic [7:0] tos_of(logic [15:0] et, logic cpl, logic [7:0] t);
    case (et)
      16'h0800, 16'h86DD: return cpl ? t : 8'h00;
      16'h0806, 16'h8035, 16'h8863: return 8'h10;
      16'h0060, 16'h9000: return 8'h08;
      default: return 8'h00;
    endcase
  endfunction

  function automatic void predict_shaper(action_t a, logic [15:0] et, logic cpl,
                                         logic [7:0] t, logic [13:0] slot,
                                         logic [15:0] l, logic [63:0] now,
                                         logic [31:0] dly);
    int c, cls, n;
    logic [13:0] h;
    logic over;
    logic [7:0] tos;
    n = 0;
    case (a)
      ACT_ENQ: begin
        tos = tos_of(et, cpl, t);
        cls = 1;
        if (tos & TosHighBit) cls--;
        if (tos & TosLowBit) cls++;
        m_count++;
        over = m_count >= m_limit;
        if (over) begin
          while (n < 63 && drop_one(c, h)) begin
            push_beat(EV_DROPPED, h, m_len[h], c[1:0], 1'b0);
            n++;
            if (m_count < m_limit) break;
          end
        end
        m_len[slot] = l;
        m_used[slot] = 1'b1;
        if (m_busy[cls]) m_link[m_tail[cls]] = slot;
        else begin
          m_head[cls] = slot; m_busy[cls] = 1'b1;
        end
        m_tail[cls] = slot;
        push_beat(over ? EV_ACC_CNG : EV_ACC, slot, l, cls[1:0], 1'b1);
      end
      ACT_HO: begin
        h = 0;
        if (sadd(now, 64'(dly) * 64'd1000) > m_next) m_next = sadd(now, 64'(dly) * 64'd1000);
        m_credit = 1'b0;
        push_beat(EV_HO_DONE, 0, 0, 0, 1'b1);
      end
      default: begin
        c = top_class();
        if (now < m_next) push_beat(EV_WAIT, 0, 0, 0, 1'b1);
        else if (m_count == 0 || c < 0) begin
          m_credit = 1'b0;
          push_beat(EV_EMPTY, 0, 0, 0, 1'b1);
        end else if (a == ACT_PEEK) begin
          push_beat(EV_PEEKED, m_head[c], m_len[m_head[c]], c[1:0], 1'b1);
        end else begin
          h = pop_class(c);
          m_count--;
          m_next = sadd(m_credit ? m_next : now, 64'(m_nspb) * 64'(m_len[h]));
          m_credit = 1'b1;
          push_beat(EV_SENT, h, m_len[h], c[1:0], 1'b1);
        end
      end
    endcase
  endfunction

  // result checker and receiver stall
  always @(posedge clk) begin
    result_t e;
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("end of test: mismatches");
      $finish;
    end
    if (rst_n && out_valid && !out_stall) begin
      if (expected_beats.size() == 0) begin
        $display("%0t: unexpected beat ev=%0d", $time, out_event_res);
        errors++;
      end else begin
        e = expected_beats.pop_front();
        if (out_event_res !== e.ev || out_handle !== e.handle || out_len !== e.len ||
            out_traffic_class !== e.cls || out_wake_time !== e.wake ||
            out_queue_count !== e.count || out_last !== e.last) begin
          $display("%0t: mismatch expected ev=%0d h=%0d l=%0d c=%0d w=%0h n=%0d last=%0b",
                   $time, e.ev, e.handle, e.len, e.cls, e.wake, e.count, e.last);
          $display("%0t:          actual ev=%0d h=%0d l=%0d c=%0d w=%0h n=%0d last=%0b",
                   $time, out_event_res, out_handle, out_len, out_traffic_class,
                   out_wake_time, out_queue_count, out_last);
          errors++;
        end
      end
    end
    out_stall <= hold_out || ($urandom_range(99) < idle_pct);
  end

  // long receiver hold-off, counted here
  task automatic hold_receiver(int n);
    hold_out = 1'b1;
    repeat (n) @(posedge clk);
    hold_out = 1'b0;
  endtask

  // valid stays high after the accepting edge; the next call drops or reloads it, and drain drops it
  task automatic send_item(action_t a, logic [15:0] et, logic cpl, logic [7:0] t,
                           logic [13:0] slot, logic [15:0] l, logic [63:0] now,
                           logic [31:0] dly);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_action <= a; in_ethertype <= et; in_header_complete <= cpl;
    in_tos_field <= t; in_packet_handle <= slot; in_packet_len <= l;
    in_now_ns <= now; in_delay_us <= dly;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predict_shaper(a, et, cpl, t, slot, l, now, dly);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (expected_beats.size() != 0) @(posedge clk);
    repeat (300) @(posedge clk);
  endtask

  task automatic write_reg(logic idx, logic [29:0] v);
    int c;
    logic [13:0] h;
    cfg_valid <= 1'b1; cfg_index <= idx; cfg_data <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    if (idx == REG_LIMIT) begin
      m_limit = v[14:0] == 0 ? 1 : v[14:0];
      if (m_count > m_limit)
        while (drop_one(c, h) && m_count >= m_limit) ;
    end else m_nspb = v == 0 ? 30'd1 : v;
    @(posedge clk);
  endtask

  // distinct slots keep link reads on written entries
  int unsigned next_slot = 0;
  function automatic logic [13:0] fresh_slot();
    next_slot = (next_slot + 1 + $urandom_range(7)) % Slots;
    return next_slot[13:0];
  endfunction

  function automatic logic [15:0] pick_et();
    case ($urandom_range(9))
      0: return 16'h0806; 1: return 16'h8035; 2: return 16'h8863;
      3: return 16'h0060; 4: return 16'h9000; 5: return 16'h86DD;
      6: return 16'($urandom);
      default: return 16'h0800;
    endcase
  endfunction

  task automatic random_item();
    action_t a;
    logic [15:0] l;
    a = action_t'($urandom_range(3));
    clock_ns = clock_ns + $urandom_range(2000000);
    l = ($urandom_range(9) == 0) ? 16'($urandom) : 16'($urandom_range(1500));
    send_item(a, pick_et(), 1'($urandom_range(1)), 8'($urandom), fresh_slot(), l,
              clock_ns, $urandom_range(3) == 0 ? $urandom : $urandom_range(200));
  endtask

  task automatic test_directed();
    send_item(ACT_DEQ, 0, 0, 0, 0, 0, 0, 0);
    send_item(ACT_PEEK, 0, 0, 0, 0, 0, 0, 0);
    send_item(ACT_ENQ, 16'h0800, 1, 8'hFF, 14'd1, 16'hFFFF, 0, 0);
    send_item(ACT_ENQ, 16'h0800, 0, 8'h10, 14'd2, 16'd0, 0, 0);
    send_item(ACT_ENQ, 16'h86DD, 1, 8'h10, 14'd3, 16'd64, 0, 0);
    send_item(ACT_ENQ, 16'h0806, 0, 0, 14'd4, 16'd100, 0, 0);
    send_item(ACT_ENQ, 16'h8035, 0, 0, 14'd5, 16'd1, 0, 0);
    send_item(ACT_ENQ, 16'h8863, 0, 0, 14'd6, 16'd2, 0, 0);
    send_item(ACT_ENQ, 16'h0060, 0, 0, 14'd7, 16'd3, 0, 0);
    send_item(ACT_ENQ, 16'h9000, 0, 0, 14'd8, 16'd4, 0, 0);
    send_item(ACT_ENQ, 16'hFFFF, 1, 8'h08, 14'd16383, 16'd5, 0, 0);
    send_item(ACT_PEEK, 0, 0, 0, 0, 0, 64'd10, 0);
    send_item(ACT_DEQ, 0, 0, 0, 0, 0, 64'd10, 0);
    send_item(ACT_DEQ, 0, 0, 0, 0, 0, 64'd11, 0);
    send_item(ACT_PEEK, 0, 0, 0, 0, 0, 64'hFFFF_FFFF_FFFF_FFF0, 0);
    send_item(ACT_DEQ, 0, 0, 0, 0, 0, 64'hFFFF_FFFF_FFFF_FFF0, 0);
    send_item(ACT_DEQ, 0, 0, 0, 0, 0, 64'hFFFF_FFFF_FFFF_FFFF, 0);
    send_item(ACT_HO, 0, 0, 0, 0, 0, 64'hFFFF_FFFF_FFFF_FF00, 32'hFFFF_FFFF);
    send_item(ACT_DEQ, 0, 0, 0, 0, 0, 64'hFFFF_FFFF_FFFF_FFFF, 0);
    drain();
  endtask

  task automatic test_limit();
    // small limit forces drops on each enqueue
    write_reg(REG_LIMIT, 30'd4);
    write_reg(REG_NSPB, 30'h3FFF_FFFF);
    repeat (12) send_item(ACT_ENQ, pick_et(), 1, 8'($urandom), fresh_slot(),
                          16'($urandom), 0, 0);
    drain();
    write_reg(REG_LIMIT, 30'd0);
    send_item(ACT_ENQ, 16'h0800, 1, 0, fresh_slot(), 16'd9, 0, 0);
    drain();
    write_reg(REG_LIMIT, 30'd16384);
    write_reg(REG_NSPB, 30'd0);
  endtask

  task automatic test_random();
    for (int i = 0; i < 110; i++) begin
      idle_pct = (i >= 40 && i < 80) ? 0 : 37;
      if (i == 20) fork hold_receiver(400); join_none
      if (i == 90) drain();
      random_item();
    end
    drain();
    write_reg(REG_LIMIT, 30'd3);
    write_reg(REG_NSPB, 30'd800);
    repeat (20) random_item();
    drain();
  endtask

  initial begin
    for (int k = 0; k < 3; k++) begin
      m_head[k] = 0; m_tail[k] = 0; m_busy[k] = 1'b0;
    end
    for (int k = 0; k < Slots; k++) begin
      m_link[k] = 0; m_len[k] = 0; m_used[k] = 1'b0;
    end
    m_count = 0; m_next = 0; m_credit = 1'b0;
    m_limit = LimitReset; m_nspb = NspbReset;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_limit();
    test_random();
    if (errors == 0 && expected_beats.size() == 0) $display("end of test: clean");
    else $display("end of test: mismatches");
    $finish;
  end
endmodule
